/* sv/bgp_open_message_parser_unit_macros.svh */
// Assertion helpers shared by the parser modules.
`ifndef BGP_OPEN_MESSAGE_PARSER_UNIT_MACROS_SVH
`define BGP_OPEN_MESSAGE_PARSER_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define BGPOP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check on every clock edge, reset included.
`define BGPOP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bgpop_pkg.sv */
`default_nettype none
package bgpop_pkg;

	localparam int MAX_PARAMS_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [12:0] MIN_OPEN = 13'd29;

	localparam int OFS_W = 5;
	localparam logic [OFS_W-1:0] OFS_VERSION = 5'd19;
	localparam logic [OFS_W-1:0] OFS_AS_HI   = 5'd20;
	localparam logic [OFS_W-1:0] OFS_AS_LO   = 5'd21;
	localparam logic [OFS_W-1:0] OFS_HOLD_HI = 5'd22;
	localparam logic [OFS_W-1:0] OFS_HOLD_LO = 5'd23;
	localparam logic [OFS_W-1:0] OFS_ID_0    = 5'd24;
	localparam logic [OFS_W-1:0] OFS_ID_1    = 5'd25;
	localparam logic [OFS_W-1:0] OFS_ID_2    = 5'd26;
	localparam logic [OFS_W-1:0] OFS_ID_3    = 5'd27;
	localparam logic [OFS_W-1:0] OFS_OPT_LEN = 5'd28;

	localparam logic [8:0] TLV_HDR = 9'd2;

	localparam logic [7:0] TYPE_AUTH  = 8'd1;
	localparam logic [7:0] TYPE_CAP   = 8'd2;
	localparam logic [7:0] CAP_MP     = 8'd1;
	localparam logic [7:0] CAP_RR     = 8'd2;
	localparam logic [7:0] CAP_RR_OLD = 8'd128;

	localparam logic [1:0] CLS_AUTH    = 2'd0;
	localparam logic [1:0] CLS_MP      = 2'd1;
	localparam logic [1:0] CLS_REFRESH = 2'd2;
	localparam logic [1:0] CLS_UNKNOWN = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_ZERO_LEN = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE = 3'd3;
	localparam logic [2:0] ST_OVERRUN  = 3'd4;
	localparam logic [2:0] ST_TOO_MANY = 3'd5;
	localparam logic [2:0] ST_TRUNC    = 3'd6;

	localparam logic KIND_PARAM   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0]  version;
		logic [15:0] as_number;
		logic [15:0] hold_time;
		logic [31:0] router_id;
		logic [7:0]  opt_length;
	} hdr_t;

	// Everything one byte produces: an optional parameter record, then an
	// optional summary record, both carrying the same header snapshot.
	typedef struct packed {
		logic        has_param;
		logic [1:0]  param_class;
		logic [7:0]  cap_byte;
		logic [7:0]  param_length;
		logic        has_summary;
		logic [2:0]  status;
		hdr_t        hdr;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage
`default_nettype wire

/* sv/bgpop_front.sv */
`default_nettype none
module bgpop_front #(
	parameter int MAX_PARAMS = bgpop_pkg::MAX_PARAMS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid,
	output logic                   ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              first,
	input  wire logic [12:0]       msg_length,
	input  wire logic              final_byte,
	input  wire bgpop_pkg::qstat_t qstat,
	output logic                   push,
	output bgpop_pkg::entry_t      entry
);

	localparam int CNT_W = $clog2(MAX_PARAMS + 1);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HDR  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_CAP  = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;

	logic [2:0]                  phase_q, phase_n, cur;
	logic [bgpop_pkg::OFS_W-1:0] ofs_q, ofs_n;
	bgpop_pkg::hdr_t             hdr_q, hdr_n;
	logic [7:0]                  rem_q, rem_n;
	logic [CNT_W-1:0]            cnt_q, cnt_n;
	logic [7:0]                  pos_q, pos_n;
	logic [7:0]                  ptype_q, ptype_n;
	logic [7:0]                  plen_q, plen_n;
	logic [8:0]                  need;
	logic                        done;
	logic                        fire;

	assign ready = !qstat.full;
	assign fire  = valid && ready;
	assign push  = fire && (entry.has_param || entry.has_summary);

	always_comb begin
		phase_n = phase_q;
		ofs_n   = ofs_q;
		hdr_n   = hdr_q;
		rem_n   = rem_q;
		cnt_n   = cnt_q;
		pos_n   = pos_q;
		ptype_n = ptype_q;
		plen_n  = plen_q;
		need    = 9'd0;
		done    = 1'b0;
		entry   = '0;

		if (first) begin
			phase_n = PH_HDR;
			ofs_n   = '0;
			hdr_n   = '0;
			rem_n   = '0;
			cnt_n   = '0;
			pos_n   = '0;
			ptype_n = '0;
			plen_n  = '0;
			if (msg_length < bgpop_pkg::MIN_OPEN) begin
				entry.has_summary = 1'b1;
				entry.status      = bgpop_pkg::ST_SHORT;
				phase_n           = PH_IDLE;
				done              = 1'b1;
			end
		end

		cur = phase_n;
		if (!done) begin
			case (cur)
				PH_HDR: begin
					case (ofs_n)
						bgpop_pkg::OFS_VERSION: hdr_n.version = data_byte;
						bgpop_pkg::OFS_AS_HI,
						bgpop_pkg::OFS_AS_LO: begin
							hdr_n.as_number = {hdr_n.as_number[7:0], data_byte};
						end
						bgpop_pkg::OFS_HOLD_HI,
						bgpop_pkg::OFS_HOLD_LO: begin
							hdr_n.hold_time = {hdr_n.hold_time[7:0], data_byte};
						end
						bgpop_pkg::OFS_ID_0, bgpop_pkg::OFS_ID_1,
						bgpop_pkg::OFS_ID_2, bgpop_pkg::OFS_ID_3: begin
							hdr_n.router_id = {hdr_n.router_id[23:0], data_byte};
						end
						bgpop_pkg::OFS_OPT_LEN: begin
							hdr_n.opt_length = data_byte;
							rem_n            = data_byte;
							if (data_byte == 8'd0) begin
								entry.has_summary = 1'b1;
								entry.status      = bgpop_pkg::ST_OK;
								phase_n           = PH_IDLE;
							end else begin
								phase_n = PH_TYPE;
							end
						end
						default: ;
					endcase
					if (ofs_n != '1)
						ofs_n = ofs_n + bgpop_pkg::OFS_W'(1);
				end
				PH_TYPE: begin
					if (cnt_n >= CNT_W'(MAX_PARAMS)) begin
						entry.has_summary = 1'b1;
						entry.status      = bgpop_pkg::ST_TOO_MANY;
						phase_n           = PH_IDLE;
					end else begin
						cnt_n   = cnt_n + CNT_W'(1);
						ptype_n = data_byte;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					plen_n = data_byte;
					need   = {1'b0, data_byte} + bgpop_pkg::TLV_HDR;
					if (data_byte == 8'd0) begin
						entry.has_summary = 1'b1;
						entry.status      = bgpop_pkg::ST_ZERO_LEN;
						phase_n           = PH_IDLE;
					end else if (ptype_n != bgpop_pkg::TYPE_AUTH &&
					             ptype_n != bgpop_pkg::TYPE_CAP) begin
						entry.has_summary = 1'b1;
						entry.status      = bgpop_pkg::ST_BAD_TYPE;
						phase_n           = PH_IDLE;
					end else if (ptype_n == bgpop_pkg::TYPE_AUTH) begin
						entry.has_param    = 1'b1;
						entry.param_class  = bgpop_pkg::CLS_AUTH;
						entry.param_length = data_byte;
						if (need > {1'b0, rem_n}) begin
							entry.has_summary = 1'b1;
							entry.status      = bgpop_pkg::ST_OVERRUN;
							phase_n           = PH_IDLE;
						end else begin
							rem_n   = rem_n - need[7:0];
							pos_n   = data_byte;
							phase_n = PH_SKIP;
						end
					end else begin
						phase_n = PH_CAP;
					end
				end
				PH_CAP: begin
					need               = {1'b0, plen_n} + bgpop_pkg::TLV_HDR;
					entry.has_param    = 1'b1;
					entry.cap_byte     = data_byte;
					entry.param_length = plen_n;
					if (data_byte == bgpop_pkg::CAP_MP)
						entry.param_class = bgpop_pkg::CLS_MP;
					else if (data_byte == bgpop_pkg::CAP_RR ||
					         data_byte == bgpop_pkg::CAP_RR_OLD)
						entry.param_class = bgpop_pkg::CLS_REFRESH;
					else
						entry.param_class = bgpop_pkg::CLS_UNKNOWN;
					if (need > {1'b0, rem_n}) begin
						entry.has_summary = 1'b1;
						entry.status      = bgpop_pkg::ST_OVERRUN;
						phase_n           = PH_IDLE;
					end else begin
						rem_n = rem_n - need[7:0];
						pos_n = plen_n - 8'd1;
						if (pos_n == 8'd0) begin
							if (rem_n == 8'd0) begin
								entry.has_summary = 1'b1;
								entry.status      = bgpop_pkg::ST_OK;
								phase_n           = PH_IDLE;
							end else begin
								phase_n = PH_TYPE;
							end
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (pos_n != 8'd0)
						pos_n = pos_n - 8'd1;
					if (pos_n == 8'd0) begin
						if (rem_n == 8'd0) begin
							entry.has_summary = 1'b1;
							entry.status      = bgpop_pkg::ST_OK;
							phase_n           = PH_IDLE;
						end else begin
							phase_n = PH_TYPE;
						end
					end
				end
				default: ;
			endcase

			// source ran dry before the message finished
			if (final_byte && phase_n != PH_IDLE) begin
				entry.has_summary = 1'b1;
				entry.status      = bgpop_pkg::ST_TRUNC;
				phase_n           = PH_IDLE;
			end
		end

		entry.hdr = hdr_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ofs_q   <= '0;
			hdr_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			ptype_q <= '0;
			plen_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			ofs_q   <= ofs_n;
			hdr_q   <= hdr_n;
			rem_q   <= rem_n;
			cnt_q   <= cnt_n;
			pos_q   <= pos_n;
			ptype_q <= ptype_n;
			plen_q  <= plen_n;
		end
	end

endmodule
`default_nettype wire

/* sv/bgpop_queue.sv */
`default_nettype none
`include "bgp_open_message_parser_unit_macros.svh"
module bgpop_queue #(
	parameter int DEPTH = bgpop_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bgpop_pkg::entry_t wr_entry,
	input  wire logic              pop,
	output bgpop_pkg::entry_t      head,
	output bgpop_pkg::qstat_t      qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bgpop_pkg::entry_t mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign head        = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`BGPOP_ASSERT_ALWAYS(a_no_push_full, !(push && qstat.full), "request pushed into full queue")
	`BGPOP_ASSERT(a_no_pop_empty, !(pop && qstat.empty), "request popped from empty queue")
	`BGPOP_ASSERT(a_cnt_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "count lost a push")

endmodule
`default_nettype wire

/* sv/bgpop_back.sv */
`default_nettype none
`include "bgp_open_message_parser_unit_macros.svh"
module bgpop_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bgpop_pkg::entry_t head,
	input  wire bgpop_pkg::qstat_t qstat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [103:0]           m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic         valid_q;
	logic [103:0] data_q;
	logic         user_q;
	logic         last_q;
	logic         sub_q;
	logic         load;
	logic         beat_param;
	logic         final_beat;
	logic [103:0] beat_data;

	assign load       = !qstat.empty && (!valid_q || m_tready);
	assign beat_param = head.has_param && !sub_q;
	assign final_beat = !beat_param || !head.has_summary;
	assign pop        = load && final_beat;

	always_comb begin
		beat_data = '0;
		beat_data[25:18] = head.hdr.version;
		beat_data[41:26] = head.hdr.as_number;
		beat_data[57:42] = head.hdr.hold_time;
		beat_data[89:58] = head.hdr.router_id;
		beat_data[97:90] = head.hdr.opt_length;
		if (beat_param) begin
			beat_data[1:0]   = head.param_class;
			beat_data[9:2]   = head.cap_byte;
			beat_data[17:10] = head.param_length;
		end else begin
			beat_data[100:98] = head.status;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= beat_data;
			user_q <= beat_param ? bgpop_pkg::KIND_PARAM : bgpop_pkg::KIND_SUMMARY;
			last_q <= !beat_param;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				// hold the entry for its summary beat
				sub_q   <= !final_beat;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	`BGPOP_ASSERT(a_sub_head, sub_q |-> (!qstat.empty && head.has_param && head.has_summary), "summary beat pending without a paired entry")
	`BGPOP_ASSERT(a_pair_hold, (load && beat_param && head.has_summary) |=> sub_q, "paired summary dropped")

endmodule
`default_nettype wire

/* sv/bgp_open_message_parser_unit.sv */
// Path: each record is queued, then loaded into the output register that drives m_tvalid.
// Throughput: one byte per cycle while the queue is not full; a byte that yields a
// parameter record and a summary sends a parameter beat and then a summary beat,
// absorbed by the QUEUE_DEPTH-entry queue. s_tready drops only while that queue is full.
// Reset: arst_n clears the parser to idle, empties the queue and drops m_tvalid at once.
`default_nettype none
module bgp_open_message_parser_unit #(
	parameter int MAX_PARAMS  = bgpop_pkg::MAX_PARAMS_DEF,
	parameter int QUEUE_DEPTH = bgpop_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [23:0]  s_tdata,  // data_byte[7:0], msg_length[20:8], zero pad
	input  wire logic         s_tuser,  // first
	input  wire logic         s_tlast,  // final_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// param_class[1:0], cap_byte[9:2], param_length[17:10], version[25:18],
	// as_number[41:26], hold_time[57:42], router_id[89:58], opt_length[97:90],
	// status[100:98], zero pad
	output logic [103:0]      m_tdata,
	output logic              m_tuser,  // record_kind
	output logic              m_tlast   // last
);

	bgpop_pkg::qstat_t qstat;
	bgpop_pkg::entry_t wr_entry;
	bgpop_pkg::entry_t head;
	logic              push;
	logic              pop;

	bgpop_front #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (s_tvalid),
		.ready     (s_tready),
		.data_byte (s_tdata[7:0]),
		.first     (s_tuser),
		.msg_length(s_tdata[20:8]),
		.final_byte(s_tlast),
		.qstat     (qstat),
		.push      (push),
		.entry     (wr_entry)
	);

	bgpop_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	bgpop_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
`default_nettype wire
